@@ rtl/core/tdlsm_pkg.sv @@
`default_nettype none

package tdlsm_pkg;

	// field and datapath widths
	localparam int FIELD_W   = 48;
	localparam int ALU_W     = 64;
	localparam int ALU_CNT_W = $clog2(ALU_W + 1);

	// shared unit operations
	localparam logic OP_DIV = 1'b0;
	localparam logic OP_MUL = 1'b1;

	// decision codes
	localparam logic [1:0] ACT_NEXT = 2'd0;
	localparam logic [1:0] ACT_STAY = 2'd1;
	localparam logic [1:0] ACT_PREV = 2'd2;

	// register indexes
	localparam logic [1:0] REG_MAX_LEVEL  = 2'd0;
	localparam logic [1:0] REG_FIXED_MODE = 2'd1;
	localparam logic [1:0] REG_UP_THR     = 2'd2;
	localparam logic [1:0] REG_DOWN_THR   = 2'd3;

	// register reset values
	localparam logic [1:0] MAX_LEVEL_RST = 2'd3;
	localparam logic       FIXED_RST     = 1'b0;
	localparam logic [6:0] UP_THR_RST    = 7'd20;
	localparam logic [6:0] DOWN_THR_RST  = 7'd10;

	// percentage scale and divisor for the two-port term
	localparam logic [6:0] SCALE      = 7'd100;
	localparam logic [6:0] FUET_DIV   = 7'd5;

	typedef logic [ALU_W-1:0] word_t;

	typedef struct packed {
		logic start;
		logic op;
	} alu_req_t;

	typedef struct packed {
		logic  done;
		word_t result;
	} alu_rsp_t;

	// level reached by a move to the next level
	function automatic logic [1:0] next_lvl_of(input logic [1:0] lvl);
		logic [1:0] nxt;
		case (lvl)
			2'd0:    nxt = 2'd1;
			2'd1:    nxt = 2'd3;
			2'd2:    nxt = 2'd2;
			default: nxt = 2'd3;
		endcase
		return nxt;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/topdown_level_switch_monitor.sv @@
`default_nettype none

// Channel   Valid          Stall          Payload
// sample    sample_valid   sample_stall   ten 48-bit counter values
// result    result_valid   result_stall   backend_bound, memory_bound, sampled_level,
//                                         action, new_level
// config    psel/penable   pready (high)  paddr, pwdata, prdata (APB)
//
// Each accepted sample runs nine operations (six divides, two multiplies, one final
// divide) on the shared 64-bit shift-and-subtract / shift-and-add unit, each made of
// a load, the iterations and a done, then a decide step; no new sample is accepted
// before the result of the current one has been written.
// sample_stall is high from acceptance until the result has been written to the
// output register; a result held by result_stall delays the decide cycle of the
// following sample, not its acceptance.
// Reset clears the level to 0 and loads the register reset values.
module topdown_level_switch_monitor #(
	parameter int COUNTER_BITS = 48
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	output logic                               sample_stall,
	input  wire logic [tdlsm_pkg::FIELD_W-1:0] clock_cycles,
	input  wire logic [tdlsm_pkg::FIELD_W-1:0] undelivered_uops,
	input  wire logic [tdlsm_pkg::FIELD_W-1:0] retire_slots,
	input  wire logic [tdlsm_pkg::FIELD_W-1:0] issued_uops,
	input  wire logic [tdlsm_pkg::FIELD_W-1:0] recovery_cycles,
	input  wire logic [tdlsm_pkg::FIELD_W-1:0] zero_port_cycles,
	input  wire logic [tdlsm_pkg::FIELD_W-1:0] one_port_cycles,
	input  wire logic [tdlsm_pkg::FIELD_W-1:0] two_port_cycles,
	input  wire logic [tdlsm_pkg::FIELD_W-1:0] memory_stall_cycles,
	input  wire logic [tdlsm_pkg::FIELD_W-1:0] store_bound_cycles,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [6:0]                         backend_bound,
	output logic [6:0]                         memory_bound,
	output logic [1:0]                         sampled_level,
	output logic [1:0]                         action,
	output logic [1:0]                         new_level,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [3:0]                    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import tdlsm_pkg::*;

	localparam int KEEP_BITS = (COUNTER_BITS < FIELD_W) ? COUNTER_BITS : FIELD_W;
	localparam logic [FIELD_W-1:0] CNT_MASK = {FIELD_W{1'b1}} >> (FIELD_W - KEEP_BITS);

	// sequencer states
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_LOAD   = 2'd1;
	localparam logic [1:0] S_RUN    = 2'd2;
	localparam logic [1:0] S_DECIDE = 2'd3;

	// operation steps
	localparam logic [3:0] ST_FB   = 4'd0;
	localparam logic [3:0] ST_BS   = 4'd1;
	localparam logic [3:0] ST_RE   = 4'd2;
	localparam logic [3:0] ST_RPC  = 4'd3;
	localparam logic [3:0] ST_PROD = 4'd4;
	localparam logic [3:0] ST_FUET = 4'd5;
	localparam logic [3:0] ST_MBF  = 4'd6;
	localparam logic [3:0] ST_MBP  = 4'd7;
	localparam logic [3:0] ST_MB   = 4'd8;

	function automatic word_t ext(input logic [FIELD_W-1:0] v);
		return {{(ALU_W-FIELD_W){1'b0}}, v & CNT_MASK};
	endfunction

	function automatic word_t times_scale(input word_t v);
		return (v << 6) + (v << 5) + (v << 2);
	endfunction

	logic [1:0] state_q;
	logic [3:0] step_q;
	logic [1:0] max_level_q;
	logic       fixed_mode_q;
	logic [6:0] up_thr_q;
	logic [6:0] down_thr_q;
	logic [1:0] cur_level_q;

	word_t cyc_q, und_q, ret_q, p2_q, pp_q, ms_q, bsn_q, slots_q;
	word_t sum_q, tmp_q;
	logic [6:0] bb_q;

	logic       result_valid_q;
	logic [6:0] backend_bound_q, memory_bound_q;
	logic [1:0] sampled_level_q, action_q, new_level_q;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	word_t    alu_a, alu_b;

	logic       sample_take;
	logic       cfg_wr;
	logic [1:0] cfg_idx;
	logic       fixed_next;
	logic       fire;

	word_t      scale_w, bb_diff;
	logic [6:0] bb_calc;
	logic [6:0] mb_sat;
	logic       bb_up, mb_up, bb_dn, mb_dn;
	logic [1:0] act, prev_lvl, target, newl;

	assign sample_stall = (state_q != S_IDLE);
	assign sample_take  = sample_valid && !sample_stall;
	assign fire         = (state_q == S_DECIDE) && (!result_valid_q || !result_stall);

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[3:2];

	always_comb begin
		fixed_next = fixed_mode_q;
		if (cfg_idx == REG_FIXED_MODE) begin
			fixed_next = pwdata[0];
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_MAX_LEVEL:  prdata = 32'(max_level_q);
			REG_FIXED_MODE: prdata = 32'(fixed_mode_q);
			REG_UP_THR:     prdata = 32'(up_thr_q);
			default:        prdata = 32'(down_thr_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_level_q  <= MAX_LEVEL_RST;
			fixed_mode_q <= FIXED_RST;
			up_thr_q     <= UP_THR_RST;
			down_thr_q   <= DOWN_THR_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_MAX_LEVEL:  max_level_q  <= pwdata[1:0];
				REG_FIXED_MODE: fixed_mode_q <= pwdata[0];
				REG_UP_THR:     up_thr_q     <= pwdata[6:0];
				default:        down_thr_q   <= pwdata[6:0];
			endcase
		end
	end

	// operand select for each step
	always_comb begin
		alu_req.start = (state_q == S_LOAD);
		alu_req.op    = OP_DIV;
		alu_a         = tmp_q;
		alu_b         = slots_q;
		unique case (step_q)
			ST_FB:   alu_a = times_scale(und_q);
			ST_BS:   alu_a = times_scale(bsn_q);
			ST_RE:   alu_a = times_scale(ret_q);
			ST_RPC: begin
				alu_a = ret_q;
				alu_b = cyc_q + word_t'(1);
			end
			ST_PROD: begin
				alu_req.op = OP_MUL;
				alu_a      = p2_q;
				alu_b      = tmp_q;
			end
			ST_FUET: alu_b = word_t'(FUET_DIV);
			ST_MBF: begin
				alu_a = times_scale(ms_q);
				alu_b = pp_q + ms_q + tmp_q + word_t'(1);
			end
			ST_MBP: begin
				alu_req.op = OP_MUL;
				alu_b      = word_t'(bb_q);
			end
			default: alu_b = word_t'(SCALE);
		endcase
	end

	tdlsm_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (alu_a),
		.b      (alu_b),
		.rsp    (alu_rsp)
	);

	// backend bound from the summed slot fractions, saturating at zero; memory bound capped at 100
	always_comb begin
		scale_w = word_t'(SCALE);
		bb_diff = scale_w - sum_q;
		bb_calc = (scale_w > sum_q) ? bb_diff[6:0] : 7'd0;
		mb_sat  = (tmp_q > scale_w) ? SCALE : tmp_q[6:0];
	end

	// level decision
	always_comb begin
		bb_up = bb_q > up_thr_q;
		mb_up = tmp_q > word_t'(up_thr_q);
		bb_dn = bb_q < down_thr_q;
		mb_dn = tmp_q < word_t'(down_thr_q);
		unique case (cur_level_q)
			2'd0: act = bb_up ? ACT_NEXT : ACT_STAY;
			2'd1: begin
				if (bb_up && mb_up) begin
					act = ACT_NEXT;
				end else if (bb_dn && mb_dn) begin
					act = ACT_PREV;
				end else begin
					act = ACT_STAY;
				end
			end
			2'd2:    act = ACT_STAY;
			default: act = (bb_up && mb_up) ? ACT_STAY : ACT_PREV;
		endcase
		unique case (cur_level_q)
			2'd3:    prev_lvl = fixed_mode_q ? 2'd3 : 2'd1;
			2'd2:    prev_lvl = 2'd1;
			default: prev_lvl = 2'd0;
		endcase
		target = (act == ACT_NEXT) ? next_lvl_of(cur_level_q) : prev_lvl;
		newl   = cur_level_q;
		if (act != ACT_STAY && target != cur_level_q && target <= max_level_q) begin
			newl = target;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			step_q         <= ST_FB;
			cur_level_q    <= 2'd0;
			result_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (sample_take) begin
						state_q <= S_LOAD;
						step_q  <= ST_FB;
					end
				end
				S_LOAD: state_q <= S_RUN;
				S_RUN: begin
					if (alu_rsp.done) begin
						if (step_q == ST_MB) begin
							state_q <= S_DECIDE;
						end else begin
							step_q  <= step_q + 1'b1;
							state_q <= S_LOAD;
						end
					end
				end
				default: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
			endcase

			// reload the level on a register write, else advance on a result
			if (cfg_wr) begin
				cur_level_q <= fixed_next ? 2'd3 : 2'd0;
			end else if (fire) begin
				cur_level_q <= newl;
			end

			if (fire) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// capture the word and hold the working values
	always_ff @(posedge clk) begin
		if (sample_take) begin
			cyc_q   <= ext(clock_cycles);
			und_q   <= ext(undelivered_uops);
			ret_q   <= ext(retire_slots);
			p2_q    <= ext(two_port_cycles);
			pp_q    <= ext(zero_port_cycles) + ext(one_port_cycles);
			ms_q    <= ext(memory_stall_cycles) + ext(store_bound_cycles);
			bsn_q   <= ext(issued_uops) - ext(retire_slots) + (ext(recovery_cycles) << 2);
			slots_q <= (ext(clock_cycles) << 2) + word_t'(1);
		end
		if (state_q == S_RUN && alu_rsp.done) begin
			if (step_q == ST_FB) begin
				sum_q <= alu_rsp.result;
			end else if (step_q == ST_BS || step_q == ST_RE) begin
				sum_q <= sum_q + alu_rsp.result;
			end else begin
				tmp_q <= alu_rsp.result;
			end
			if (step_q == ST_RPC) begin
				bb_q <= bb_calc;
			end
		end
		if (fire) begin
			backend_bound_q <= bb_q;
			memory_bound_q  <= mb_sat;
			sampled_level_q <= cur_level_q;
			action_q        <= act;
			new_level_q     <= newl;
		end
	end

	assign result_valid  = result_valid_q;
	assign backend_bound = backend_bound_q;
	assign memory_bound  = memory_bound_q;
	assign sampled_level = sampled_level_q;
	assign action        = action_q;
	assign new_level     = new_level_q;

`ifndef SYNTHESIS
	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		sample_take |=> (state_q == S_LOAD) && (step_q == ST_FB))
		else $error("accepted word did not start the first step");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (step_q <= ST_MB))
		else $error("step index out of range");

	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> (state_q == S_RUN))
		else $error("unit finished outside the run state");

	a_stay_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && action == ACT_STAY) |-> (new_level == sampled_level))
		else $error("stay decision changed the level");
`endif

endmodule

`default_nettype wire

@@ rtl/core/tdlsm_alu.sv @@
`default_nettype none

module tdlsm_alu (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tdlsm_pkg::alu_req_t req,
	input  wire tdlsm_pkg::word_t    a,
	input  wire tdlsm_pkg::word_t    b,
	output tdlsm_pkg::alu_rsp_t      rsp
);
	import tdlsm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic                 op_q;
	logic                 bzero_q;
	logic [ALU_CNT_W-1:0] cnt_q;
	word_t                acc_q;
	word_t                sh_q;
	word_t                md_q;

	logic [ALU_W:0]   rem_sh;
	logic [ALU_W+1:0] add_x;
	logic [ALU_W+1:0] add_y;
	logic [ALU_W+1:0] add_sum;
	logic             sub;
	logic             neg;

	// shared adder: subtract for a divide step, add for a multiply step
	always_comb begin
		rem_sh = {acc_q, sh_q[ALU_W-1]};
		sub    = (op_q == OP_DIV);
		if (sub) begin
			add_x = {1'b0, rem_sh};
		end else begin
			add_x = {2'b00, acc_q};
		end
		add_y   = {2'b00, md_q};
		add_sum = add_x + (sub ? ~add_y : add_y) + {{(ALU_W+1){1'b0}}, sub};
		neg     = add_sum[ALU_W+1];
	end

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ALU_CNT_W'(ALU_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ALU_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one bit of quotient or one partial product per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q    <= req.op;
			acc_q   <= '0;
			bzero_q <= (b == '0);
			if (req.op == OP_MUL) begin
				md_q <= a;
				sh_q <= b;
			end else begin
				md_q <= b;
				sh_q <= a;
			end
		end else if (busy_q) begin
			if (op_q == OP_DIV) begin
				acc_q <= neg ? rem_sh[ALU_W-1:0] : add_sum[ALU_W-1:0];
				sh_q  <= {sh_q[ALU_W-2:0], ~neg};
			end else begin
				if (sh_q[0]) begin
					acc_q <= add_sum[ALU_W-1:0];
				end
				md_q <= {md_q[ALU_W-2:0], 1'b0};
				sh_q <= {1'b0, sh_q[ALU_W-1:1]};
			end
		end
	end

	// a zero divisor gives a zero quotient
	always_comb begin
		rsp.done = done_q;
		if (op_q == OP_MUL) begin
			rsp.result = acc_q;
		end else begin
			rsp.result = bzero_q ? '0 : sh_q;
		end
	end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
module tb_top;
	import tdlsm_pkg::*;

	localparam logic [63:0] PCT   = 64'd100;
	localparam logic [63:0] LANES = 64'd4;

	// one counter sample as presented on the sample channel
	typedef struct packed {
		logic [FIELD_W-1:0] clock_cycles;
		logic [FIELD_W-1:0] undelivered_uops;
		logic [FIELD_W-1:0] retire_slots;
		logic [FIELD_W-1:0] issued_uops;
		logic [FIELD_W-1:0] recovery_cycles;
		logic [FIELD_W-1:0] zero_port_cycles;
		logic [FIELD_W-1:0] one_port_cycles;
		logic [FIELD_W-1:0] two_port_cycles;
		logic [FIELD_W-1:0] memory_stall_cycles;
		logic [FIELD_W-1:0] store_bound_cycles;
	} sample_t;

	// percentages and level decision for one sample
	typedef struct packed {
		logic [6:0] backend_bound;
		logic [6:0] memory_bound;
		logic [1:0] sampled_level;
		logic [1:0] action;
		logic [1:0] new_level;
	} verdict_t;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_stall;
	sample_t     drv          = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [6:0]  backend_bound;
	logic [6:0]  memory_bound;
	logic [1:0]  sampled_level;
	logic [1:0]  action;
	logic [1:0]  new_level;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [3:0]  paddr        = '0;
	logic [31:0] pwdata       = '0;
	logic [31:0] prdata;
	logic        pready;

	// shadow of the block's registers and level
	logic [1:0]  cfg_max      = MAX_LEVEL_RST;
	logic        cfg_fixed    = FIXED_RST;
	logic [6:0]  cfg_up       = UP_THR_RST;
	logic [6:0]  cfg_down     = DOWN_THR_RST;
	logic [1:0]  cur_level    = 2'd0;

	sample_t     counter_samples[$];
	verdict_t    level_verdicts[$];
	verdict_t    judged;
	verdict_t    want;
	logic        fixed_after;
	logic        calm         = 1'b0;
	int          gap_left     = 0;
	int          hold_left    = 0;
	int          coin_tx;
	int          coin_rx;
	int          fault_count  = 0;

	topdown_level_switch_monitor u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.sample_valid        (sample_valid),
		.sample_stall        (sample_stall),
		.clock_cycles        (drv.clock_cycles),
		.undelivered_uops    (drv.undelivered_uops),
		.retire_slots        (drv.retire_slots),
		.issued_uops         (drv.issued_uops),
		.recovery_cycles     (drv.recovery_cycles),
		.zero_port_cycles    (drv.zero_port_cycles),
		.one_port_cycles     (drv.one_port_cycles),
		.two_port_cycles     (drv.two_port_cycles),
		.memory_stall_cycles (drv.memory_stall_cycles),
		.store_bound_cycles  (drv.store_bound_cycles),
		.result_valid        (result_valid),
		.result_stall        (result_stall),
		.backend_bound       (backend_bound),
		.memory_bound        (memory_bound),
		.sampled_level       (sampled_level),
		.action              (action),
		.new_level           (new_level),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.prdata              (prdata),
		.pready              (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] quot(input logic [63:0] a, input logic [63:0] b);
		return (b == 64'd0) ? 64'd0 : a / b;
	endfunction

	function automatic logic [FIELD_W-1:0] rand48();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[FIELD_W-1:0];
	endfunction

	// work out both percentages, the decision and the level it leads to
	function automatic verdict_t classify_sample(input sample_t s, input logic [1:0] lvl);
		logic [63:0] cyc, ret, up, dn, slots, fb, bs, re, total, bb, fuet, bbc, mbf, mb;
		logic        hi, lo;
		logic [1:0]  act, tgt, nl;
		verdict_t    v;
		cyc   = 64'(s.clock_cycles);
		ret   = 64'(s.retire_slots);
		up    = 64'(cfg_up);
		dn    = 64'(cfg_down);
		slots = LANES * cyc + 64'd1;
		fb    = quot(PCT * 64'(s.undelivered_uops), slots);
		bs    = quot(PCT * (64'(s.issued_uops) - ret + LANES * 64'(s.recovery_cycles)), slots);
		re    = quot(PCT * ret, slots);
		total = fb + bs + re;
		bb    = (total < PCT) ? PCT - total : 64'd0;
		fuet  = quot(64'(s.two_port_cycles) * quot(ret, cyc + 64'd1), LANES + 64'd1);
		bbc   = 64'(s.zero_port_cycles) + 64'(s.one_port_cycles) + fuet
			+ 64'(s.memory_stall_cycles) + 64'(s.store_bound_cycles);
		mbf   = quot(PCT * (64'(s.memory_stall_cycles) + 64'(s.store_bound_cycles)),
			bbc + 64'd1);
		mb    = (mbf * bb) / PCT;
		hi    = (bb > up) && (mb > up);
		lo    = (bb < dn) && (mb < dn);
		case (lvl)
			2'd0:    act = (bb > up) ? ACT_NEXT : ACT_STAY;
			2'd1:    act = hi ? ACT_NEXT : (lo ? ACT_PREV : ACT_STAY);
			2'd2:    act = ACT_STAY;
			default: act = hi ? ACT_STAY : ACT_PREV;
		endcase
		// follow the move tables, refuse moves past the ceiling
		nl = lvl;
		if (act != ACT_STAY) begin
			if (act == ACT_NEXT) begin
				case (lvl)
					2'd0:    tgt = 2'd1;
					2'd1:    tgt = 2'd3;
					2'd2:    tgt = 2'd2;
					default: tgt = 2'd3;
				endcase
			end else begin
				case (lvl)
					2'd3:    tgt = cfg_fixed ? 2'd3 : 2'd1;
					2'd2:    tgt = 2'd1;
					default: tgt = 2'd0;
				endcase
			end
			if (tgt != lvl && tgt <= cfg_max)
				nl = tgt;
		end
		v.backend_bound = bb[6:0];
		v.memory_bound  = (mb > PCT) ? 7'd100 : mb[6:0];
		v.sampled_level = lvl;
		v.action        = act;
		v.new_level     = nl;
		return v;
	endfunction

	// build a sample whose slot shares and memory share sit near the given percentages
	function automatic sample_t shaped_sample(input logic [FIELD_W-1:0] cyc, input int fe,
			input int bsp, input int rep, input int mshare);
		logic [63:0] slots, bsv, rec, unit, mem;
		sample_t     s;
		slots                 = LANES * 64'(cyc) + 64'd1;
		bsv                   = slots * 64'(bsp) / PCT;
		rec                   = bsv >> $urandom_range(2, 46);
		unit                  = 64'd1 << $urandom_range(0, 30);
		mem                   = unit * 64'(mshare);
		s.clock_cycles        = cyc;
		s.undelivered_uops    = FIELD_W'(slots * 64'(fe) / PCT);
		s.retire_slots        = FIELD_W'(slots * 64'(rep) / PCT);
		s.issued_uops         = FIELD_W'(64'(s.retire_slots) + bsv - LANES * rec);
		s.recovery_cycles     = FIELD_W'(rec);
		s.zero_port_cycles    = FIELD_W'(unit * 64'(100 - mshare));
		s.one_port_cycles     = rand48() & FIELD_W'(unit - 64'd1);
		s.two_port_cycles     = rand48() & FIELD_W'(unit - 64'd1);
		s.store_bound_cycles  = FIELD_W'(mem >> $urandom_range(1, 8));
		s.memory_stall_cycles = FIELD_W'(mem - 64'(s.store_bound_cycles));
		return s;
	endfunction

	task automatic log_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("tb_top: %s", msg);
	endtask

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned got_v);
		if (exp_v != got_v)
			log_fault($sformatf("%s mismatch: expected %0d, got %0d", name, exp_v, got_v));
	endtask

	// present the next word, hold it while stalled, mirror register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			drv          <= '0;
			gap_left     <= 0;
			cur_level    <= 2'd0;
			cfg_max      <= MAX_LEVEL_RST;
			cfg_fixed    <= FIXED_RST;
			cfg_up       <= UP_THR_RST;
			cfg_down     <= DOWN_THR_RST;
		end else begin
			// any register write reloads the level
			if (psel && penable && pwrite && pready) begin
				fixed_after = cfg_fixed;
				case (paddr[3:2])
					REG_MAX_LEVEL:  cfg_max <= pwdata[1:0];
					REG_FIXED_MODE: begin
						cfg_fixed   <= pwdata[0];
						fixed_after = pwdata[0];
					end
					REG_UP_THR:     cfg_up <= pwdata[6:0];
					REG_DOWN_THR:   cfg_down <= pwdata[6:0];
				endcase
				cur_level <= fixed_after ? 2'd3 : 2'd0;
			end
			if (sample_valid && !sample_stall) begin
				judged = classify_sample(drv, cur_level);
				level_verdicts.push_back(judged);
				cur_level <= judged.new_level;
			end
			if (!(sample_valid && sample_stall)) begin
				if (gap_left != 0) begin
					gap_left     <= gap_left - 1;
					sample_valid <= 1'b0;
				end else if (counter_samples.size() != 0) begin
					drv          <= counter_samples.pop_front();
					sample_valid <= 1'b1;
					coin_tx      = $urandom_range(0, 99);
					if (calm || coin_tx < 70)
						gap_left <= 0;
					else if (coin_tx < 96)
						gap_left <= $urandom_range(1, 6);
					else
						gap_left <= $urandom_range(100, 800);
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// take result words, compare with the oldest prediction, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left    <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (level_verdicts.size() == 0) begin
					log_fault($sformatf("result word with nothing outstanding (bb %0d, mb %0d)",
						backend_bound, memory_bound));
				end else begin
					want = level_verdicts.pop_front();
					check_field("backend_bound", want.backend_bound, backend_bound);
					check_field("memory_bound", want.memory_bound, memory_bound);
					check_field("sampled_level", want.sampled_level, sampled_level);
					check_field("action", want.action, action);
					check_field("new_level", want.new_level, new_level);
				end
			end
			if (calm) begin
				result_stall <= 1'b0;
				hold_left    <= 0;
			end else if (hold_left != 0) begin
				result_stall <= 1'b1;
				hold_left    <= hold_left - 1;
			end else begin
				coin_rx = $urandom_range(0, 2999);
				if (coin_rx == 0) begin
					result_stall <= 1'b1;
					hold_left    <= $urandom_range(100, 900);
				end else if (coin_rx < 900) begin
					result_stall <= 1'b1;
					hold_left    <= $urandom_range(0, 4);
				end else begin
					result_stall <= 1'b0;
				end
			end
		end
	end

	// phases of register settings, each followed by a batch of samples
	initial begin
		logic [1:0]       reg_order[4];
		logic [31:0]      reg_mask[4];
		logic [31:0]      reg_val[4];
		int               set_max[8];
		int               set_fixed[8];
		int               set_up[8];
		int               set_down[8];
		logic [9:0][47:0] raw;
		sample_t          s;
		int               t, fe, bsp;
		reg_order = '{REG_MAX_LEVEL, REG_FIXED_MODE, REG_UP_THR, REG_DOWN_THR};
		reg_mask  = '{32'h3, 32'h1, 32'h7f, 32'h7f};
		set_max   = '{3, 0, 1, 2, 3, 1, 3, 3};
		set_fixed = '{0, 0, 0, 1, 1, 1, 0, 0};
		set_up    = '{20, 0, 127, 50, 100, 20, 5, 101};
		set_down  = '{10, 0, 127, 30, 100, 10, 60, 0};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < 12; p++) begin
			calm = (p == 2 || p == 9);
			if (p > 0) begin
				if (p < 8) begin
					reg_val = '{set_max[p], set_fixed[p], set_up[p], set_down[p]};
				end else begin
					reg_val[0] = $urandom_range(0, 3);
					reg_val[1] = ($urandom_range(0, 3) == 0);
					reg_val[2] = $urandom_range(0, 70);
					reg_val[3] = $urandom_range(0, 40);
				end
				// write every register, junk above the field width
				for (int i = 0; i < 4; i++) begin
					@(posedge clk);
					psel    <= 1'b1;
					penable <= 1'b0;
					pwrite  <= 1'b1;
					paddr   <= {reg_order[i], 2'b00};
					pwdata  <= reg_val[i] | ($urandom & ~reg_mask[i]);
					@(posedge clk);
					penable <= 1'b1;
					do @(posedge clk); while (!pready);
					psel    <= 1'b0;
					penable <= 1'b0;
					pwrite  <= 1'b0;
				end
				@(negedge clk);
			end else begin
				// walk the levels: up, up, hold, back, hold, back, hold
				s = '0;
				counter_samples.push_back(s);
				counter_samples.push_back(shaped_sample(48'd1000000, 10, 10, 10, 90));
				counter_samples.push_back(shaped_sample(48'd1000000, 10, 10, 10, 90));
				counter_samples.push_back(shaped_sample(48'd777777, 20, 10, 20, 10));
				counter_samples.push_back(shaped_sample(48'd777777, 20, 10, 20, 10));
				counter_samples.push_back(shaped_sample(48'd123456, 40, 30, 30, 5));
				counter_samples.push_back(shaped_sample(48'd123456, 40, 30, 30, 5));
				// field extremes and bit patterns
				counter_samples.push_back(sample_t'({10{48'hffff_ffff_ffff}}));
				counter_samples.push_back(sample_t'({10{48'haaaa_aaaa_aaaa}}));
				counter_samples.push_back(sample_t'({10{48'h5555_5555_5555}}));
				// no cycles, issued below retired: the bad-speculation term wraps
				raw = '0;
				s = sample_t'(raw);
				s.retire_slots        = '1;
				s.undelivered_uops    = rand48();
				s.memory_stall_cycles = rand48();
				counter_samples.push_back(s);
				s = '0;
				s.clock_cycles = '1;
				counter_samples.push_back(s);
			end
			for (int n = 0; n < ((p == 0) ? 84 : 96); n++) begin
				if ($urandom_range(0, 4) == 0) begin
					for (int f = 0; f < 10; f++)
						raw[f] = $urandom_range(0, 1) ? rand48() : rand48() >> $urandom_range(1, 47);
					s = sample_t'(raw);
				end else begin
					t   = $urandom_range(0, 100);
					fe  = $urandom_range(0, t);
					bsp = $urandom_range(0, t - fe);
					s   = shaped_sample(rand48() >> $urandom_range(4, 47), fe, bsp, t - fe - bsp,
						$urandom_range(0, 100));
				end
				counter_samples.push_back(s);
			end
			// drain before touching the registers again
			do @(negedge clk);
			while (counter_samples.size() != 0 || sample_valid || level_verdicts.size() != 0);
		end

		repeat (700) @(negedge clk);
		if (fault_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// give up well past the slowest legal run
	initial begin
		#80000000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
